[rtl/integer_to_ascii_radix_assert.svh]
// assertion macros shared by the checker
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/i2a_pkg.sv]
package i2a_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_VALUE_W = 32;
    localparam int RADIX_W    = 5;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;

    // request tdata layout
    localparam int RADIX_LSB  = 32;
    localparam int UPPER_BIT  = 37;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEP    = 8;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    typedef enum logic
    {
        REQ_UNSIGNED   = 1'b0,
        REQ_SIGNED_DEC = 1'b1
    } req_type_t;

    localparam radix_t BASE_MIN = 5'd2;
    localparam radix_t BASE_MAX = 5'd16;
    localparam radix_t BASE_DEC = 5'd10;

    localparam char_t CHAR_ZERO    = 7'h30;
    localparam char_t CHAR_LOWER_A = 7'h61;
    localparam char_t CHAR_UPPER_A = 7'h41;
    localparam char_t CHAR_MINUS   = 7'h2d;
    localparam char_t DIGIT_TEN    = 7'd10;
    localparam digit_t DIGIT_NINE  = 4'd9;

    // classified request, magnitude travels beside it
    typedef struct packed
    {
        logic   neg;
        logic   upper;
        radix_t base;
    } cls_t;

    function automatic char_t digit_char(input digit_t d, input logic upper);
        char_t d_ext;
        d_ext = {3'b000, d};
        if (d <= DIGIT_NINE)
        begin
            return CHAR_ZERO + d_ext;
        end
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + d_ext - DIGIT_TEN;
    endfunction

endpackage

[rtl/integer_to_ascii_radix.sv]
// Integer to ASCII converter. Each request carries a number, a base from 2 to 16
// (0 and 1 act as 2, 17 and above as 16), an upper-case flag and a request type:
// unsigned in the given base, or signed decimal with a leading '-' for negative
// values. The block streams the ASCII characters most significant digit first,
// without leading zeros, and raises tlast on the final one; zero prints as '0'.
// Requests are classified on entry and held in a two-deep queue. The back end
// divides by the base in a shared restoring divider that handles eight bits a
// cycle and works through the whole value once per digit. It then replays the
// digits from a small digit buffer, reading each digit from the buffer before
// it is sent. A minus sign goes out while the first digit is read from the
// buffer.
// The last character can wait in the output register while the next request
// is already being divided.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // value[31:0], radix[36:32], upper_case[37], zero pad
    input  logic [i2a_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[0]
    input  logic [i2a_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // char_code[6:0], zero pad
    output logic [i2a_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import i2a_pkg::*;

    localparam int CLS_W = $bits(cls_t);
    localparam int DW    = CLS_W + VALUE_WIDTH;

    logic                   q_push;
    logic                   q_full;
    cls_t                   push_cls;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic [DW-1:0]          push_data;
    logic                   q_pop;
    logic                   q_empty;
    logic [DW-1:0]          pop_data;
    cls_t                   pop_cls;
    logic [VALUE_WIDTH-1:0] pop_mag;

    assign push_data = {push_mag, push_cls};
    assign pop_cls   = cls_t'(pop_data[CLS_W-1:0]);
    assign pop_mag   = pop_data[DW-1:CLS_W];

    i2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cls         (push_cls),
        .q_mag         (push_mag)
    );

    i2a_fifo #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    i2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_cls         (pop_cls),
        .q_mag         (pop_mag),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/i2a_front.sv]
module i2a_front #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // value[31:0], radix[36:32], upper_case[37], zero pad
    input  logic [i2a_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[0]
    input  logic [i2a_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output i2a_pkg::cls_t                 q_cls,
    output logic [VALUE_WIDTH-1:0]        q_mag
);
    import i2a_pkg::*;

    logic [VALUE_WIDTH+IN_VALUE_W-1:0] value_wide;
    logic [VALUE_WIDTH-1:0]            value_ext;
    radix_t                            radix_in;
    logic                              signed_req;

    assign value_wide    = {{VALUE_WIDTH{1'b0}}, s_axis_tdata[IN_VALUE_W-1:0]};
    assign value_ext     = value_wide[VALUE_WIDTH-1:0];
    assign radix_in      = s_axis_tdata[RADIX_LSB +: RADIX_W];
    assign signed_req    = (req_type_t'(s_axis_tuser[0]) == REQ_SIGNED_DEC);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_cls.upper = s_axis_tdata[UPPER_BIT];
        q_cls.neg   = 1'b0;
        q_mag       = value_ext;
        priority if (signed_req)
        begin
            q_cls.base  = BASE_DEC;
            q_cls.upper = 1'b0;
            q_cls.neg   = value_ext[VALUE_WIDTH-1];
            if (value_ext[VALUE_WIDTH-1])
            begin
                q_mag = {VALUE_WIDTH{1'b0}} - value_ext;
            end
        end
        else if (radix_in < BASE_MIN)
        begin
            q_cls.base = BASE_MIN;
        end
        else if (radix_in > BASE_MAX)
        begin
            q_cls.base = BASE_MAX;
        end
        else
        begin
            q_cls.base = radix_in;
        end
    end

endmodule

[rtl/i2a_fifo.sv]
module i2a_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = i2a_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          empty
);
    import i2a_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/i2a_back.sv]
module i2a_back #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  i2a_pkg::cls_t                 q_cls,
    input  logic [VALUE_WIDTH-1:0]        q_mag,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // char_code[6:0], zero pad
    output logic [i2a_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import i2a_pkg::*;

    localparam int PASSES = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int PW     = PASSES * DIV_STEP;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int ADDR_W = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // eight restoring steps of division by the base
    function automatic logic [DIGIT_W+DIV_STEP-1:0] div_step(
        input logic [DIV_STEP-1:0] chunk,
        input digit_t              r_in,
        input radix_t              b
    );
        logic [DIGIT_W:0]    t;
        digit_t              r;
        logic [DIV_STEP-1:0] q;
        r = r_in;
        q = '0;
        for (int i = DIV_STEP - 1; i >= 0; i--)
        begin
            t = {r, chunk[i]};
            if (t >= b)
            begin
                t    = t - b;
                q[i] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        return {r, q};
    endfunction

    state_t              state_reg,   state_next;
    logic [PW-1:0]       sh_reg,      sh_next;
    digit_t              rem_reg,     rem_next;
    logic [PASS_W-1:0]   pass_reg,    pass_next;
    logic [ADDR_W-1:0]   wr_idx_reg,  wr_idx_next;
    logic [ADDR_W-1:0]   idx_reg,     idx_next;
    logic                fresh_reg,   fresh_next;
    radix_t              base_reg,    base_next;
    logic                neg_reg,     neg_next;
    logic                upper_reg,   upper_next;
    char_t               out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    digit_t              digit_mem [VALUE_WIDTH];
    digit_t              rd_data_reg;

    logic [DIGIT_W+DIV_STEP-1:0] step;
    digit_t                      step_rem;
    logic [PW-1:0]               sh_step;
    logic                        dig_we;
    logic                        out_free;

    assign step     = div_step(sh_reg[PW-1 -: DIV_STEP], rem_reg, base_reg);
    assign step_rem = step[DIGIT_W+DIV_STEP-1:DIV_STEP];
    assign sh_step  = (sh_reg << DIV_STEP) | PW'(step[DIV_STEP-1:0]);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        pass_next      = pass_reg;
        wr_idx_next    = wr_idx_reg;
        idx_next       = idx_reg;
        fresh_next     = 1'b1;
        base_next      = base_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        q_pop          = 1'b0;
        dig_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    sh_next     = PW'(q_mag);
                    rem_next    = '0;
                    pass_next   = '0;
                    wr_idx_next = '0;
                    base_next   = q_cls.base;
                    neg_next    = q_cls.neg;
                    upper_next  = q_cls.upper;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                sh_next = sh_step;
                if (pass_reg == PASS_W'(PASSES - 1))
                begin
                    dig_we      = 1'b1;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    rem_next    = '0;
                    pass_next   = '0;
                    if (sh_step == '0)
                    begin
                        idx_next   = wr_idx_reg;
                        fresh_next = 1'b0;
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
                else
                begin
                    rem_next  = step_rem;
                    pass_next = pass_reg + 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (fresh_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = digit_char(rd_data_reg, upper_reg);
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        fresh_next = 1'b0;
                    end
                end
            end
        endcase
    end

    // digit buffer, written low digit first, read back high digit first
    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            digit_mem[wr_idx_reg] <= step_rem;
        end
        rd_data_reg <= digit_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sh_reg        <= '0;
            rem_reg       <= '0;
            pass_reg      <= '0;
            wr_idx_reg    <= '0;
            idx_reg       <= '0;
            fresh_reg     <= 1'b0;
            base_reg      <= BASE_DEC;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            rem_reg       <= rem_next;
            pass_reg      <= pass_next;
            wr_idx_reg    <= wr_idx_next;
            idx_reg       <= idx_next;
            fresh_reg     <= fresh_next;
            base_reg      <= base_next;
            neg_reg       <= neg_next;
            upper_reg     <= upper_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/i2a_checker.sv]
`include "integer_to_ascii_radix_assert.svh"

module i2a_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [i2a_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import i2a_pkg::*;

    char_t m_char;
    logic  is_dec;
    logic  is_lower;
    logic  is_upper;
    logic  is_minus;
    logic  char_ok;

    assign m_char   = m_axis_tdata[CHAR_W-1:0];
    assign is_dec   = (m_char >= CHAR_ZERO) && (m_char <= CHAR_ZERO + 7'd9);
    assign is_lower = (m_char >= CHAR_LOWER_A) && (m_char <= CHAR_LOWER_A + 7'd5);
    assign is_upper = (m_char >= CHAR_UPPER_A) && (m_char <= CHAR_UPPER_A + 7'd5);
    assign is_minus = (m_char == CHAR_MINUS);
    assign char_ok  = (is_dec || is_lower || is_upper || is_minus)
                      && (m_axis_tdata[M_TDATA_W-1:CHAR_W] == '0);

    // stalled character holds
    `I2A_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed under stall")
    // only digits, letters a-f or A-F and minus
    `I2A_ASSERT_NOW(a_char_set, m_axis_tvalid, char_ok, "character outside digit set")
    // sign is never the final character
    `I2A_ASSERT_NOW(a_minus_not_last, m_axis_tvalid && is_minus, !m_axis_tlast, "minus marked last")
    // an accepted sign is not directly followed by another sign
    `I2A_ASSERT_NEXT(a_minus_single, m_axis_tvalid && m_axis_tready && is_minus,
        !(m_axis_tvalid && is_minus), "two signs in a row")

endmodule

bind integer_to_ascii_radix i2a_checker u_i2a_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
